/* src/gbl_pkg.sv */
// Shared types and constants for the Gaussian blur block.
`default_nettype none
package gbl_pkg;

  localparam logic [1:0] MODE_3X3  = 2'd0;
  localparam logic [1:0] MODE_G273 = 2'd1;
  localparam logic [1:0] MODE_P324 = 2'd2;

  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_MODE   = 2'd2;
  // unlisted index, writes to it are ignored
  localparam logic [1:0] REG_SPARE  = 2'd3;

  // reciprocal multipliers, quotient = (sum * M) >> DIV_SHIFT
  localparam int          DIV_SHIFT = 25;
  localparam logic [21:0] MUL_3X3   = 22'd2097152;
  localparam logic [21:0] MUL_273   = 22'd122911;
  localparam logic [21:0] MUL_324   = 22'd103564;

  typedef struct packed {
    logic       emit;
    logic       fend;
    logic       raw_sel;
    logic [2:0] sel;
  } meta_t;

  typedef struct packed {
    logic        v;
    logic        wr;
    logic [1:0]  slot;
    logic [10:0] addr;
    logic [7:0]  pixel;
    meta_t       meta;
  } req_t;

  // element k is row (current - k) of one column
  typedef logic [4:0][7:0] col_t;

endpackage
`default_nettype wire

/* src/gaussian_blur_gray8_3x3_5x5.sv */
// Top level of the streaming Gaussian blur: history taps and output register.
// Usage:
//   Input stream s_*: s_tuser is the command (0 pixel, 1 drain), s_tdata the
//   grey pixel. Pixels arrive in raster order. After a whole frame is taken,
//   drain items flush the remaining buffered outputs, one per item.
//   Output stream m_*: m_tdata is the blurred pixel in raster order, m_tlast
//   is high on every result, m_tuser marks the final pixel of the frame.
//   Configuration channel cfg_*: index 0 width, 1 height, 2 kernel mode;
//   a write to any of these restarts the frame. Write only while the block is idle.
// Throughput: one item per cycle while the output is not stalled. From the
// accepting edge of an item, the row bank read register loads, then window,
// class sums, kernel weighting, reciprocal multiply and the output register
// follow in that order until its result is on m_*.
// Outputs lag the input stream by radius*width + 2*radius items.
// Reset sets width 1024, height 768, mode 1 and clears all positions;
// row banks are not cleared. When m_tready is low with a result waiting,
// the whole pipeline holds and s_tready drops; nothing is lost or repeated.
`default_nettype none
module gaussian_blur_gray8_3x3_5x5 #(
  parameter int MAX_WIDTH = 1024
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         s_tvalid,
  output logic        s_tready,
  input  wire  [7:0]  s_tdata,   // [7:0] pixel_in
  input  wire         s_tuser,   // [0] command
  output logic        m_tvalid,
  input  wire         m_tready,
  output logic [7:0]  m_tdata,   // [7:0] pixel_out
  output logic        m_tlast,
  output logic        m_tuser,   // [0] frame_end
  input  wire         cfg_valid,
  output logic        cfg_ready,
  input  wire  [1:0]  cfg_index,
  input  wire  [11:0] cfg_data
);
  import gbl_pkg::*;

  logic       adv;
  req_t       req;
  logic [1:0] mode;
  logic       v1, v5;
  meta_t      meta1, meta5;
  col_t       column;
  logic [7:0] raw5, q5;
  logic [7:0] bh [5];
  logic [7:0] rh [5];
  logic [7:0] bh_new [5];
  logic [7:0] rh_new [5];
  logic [7:0] pix;

  assign adv       = !m_tvalid || m_tready;
  assign s_tready  = adv;
  assign cfg_ready = 1'b1;

  gbl_ctrl #(.MAX_WIDTH(MAX_WIDTH)) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .s_tvalid  (s_tvalid),
    .s_tuser   (s_tuser),
    .s_tdata   (s_tdata),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req       (req),
    .mode      (mode)
  );

  gbl_linebuf #(.MAX_WIDTH(MAX_WIDTH)) u_linebuf (
    .clk    (clk),
    .rst    (rst),
    .adv    (adv),
    .req    (req),
    .v1     (v1),
    .meta1  (meta1),
    .column (column)
  );

  gbl_filter u_filter (
    .clk    (clk),
    .rst    (rst),
    .adv    (adv),
    .mode   (mode),
    .v1     (v1),
    .meta1  (meta1),
    .column (column),
    .v5     (v5),
    .meta5  (meta5),
    .raw5   (raw5),
    .q5     (q5)
  );

  // entry 0 is the current item, entry k the item k places earlier
  always_comb begin
    bh_new[0] = q5;
    rh_new[0] = raw5;
    for (int k = 1; k < 5; k++) begin
      bh_new[k] = bh[k-1];
      rh_new[k] = rh[k-1];
    end
    if (meta5.raw_sel) begin
      pix = (mode != MODE_3X3) ? rh_new[4] : rh_new[2];
    end else begin
      pix = bh_new[meta5.sel];
    end
  end

  always_ff @(posedge clk) begin
    if (adv && v5) begin
      for (int k = 0; k < 5; k++) begin
        bh[k] <= bh_new[k];
        rh[k] <= rh_new[k];
      end
    end
    if (adv) begin
      m_tdata <= pix;
      m_tuser <= meta5.fend;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (adv) begin
      m_tvalid <= v5 && meta5.emit;
    end
  end

  assign m_tlast = 1'b1;

endmodule
`default_nettype wire

/* src/gbl_ctrl.sv */
// Frame position counters, configuration registers and output selection.
`default_nettype none
module gbl_ctrl #(
  parameter int MAX_WIDTH = 1024
) (
  input  wire               clk,
  input  wire               rst,
  input  wire               adv,
  input  wire               s_tvalid,
  input  wire               s_tuser,
  input  wire  [7:0]        s_tdata,
  input  wire               cfg_valid,
  input  wire  [1:0]        cfg_index,
  input  wire  [11:0]       cfg_data,
  output gbl_pkg::req_t     req,
  output logic [1:0]        mode
);
  import gbl_pkg::*;

  logic [10:0] width;
  logic [11:0] height;
  logic [10:0] col;
  logic [11:0] row;
  logic [1:0]  slot;
  logic        done;
  logic [12:0] lead;
  logic [10:0] ocol;
  logic [11:0] orow;

  logic        rad2;
  logic [11:0] kdim;
  logic        geom_ok;
  logic [12:0] delay;
  logic        take;
  logic        emit;
  logic        last;
  logic        col_wrap;
  logic [10:0] rlo;
  logic [2:0]  sel;
  logic        raw_sel;
  logic [10:0] rlim;
  logic [10:0] rsel;

  always_comb begin
    rad2     = (mode != MODE_3X3);
    kdim     = rad2 ? 12'd5 : 12'd3;
    geom_ok  = ({1'b0, width} >= kdim) && (32'(width) <= MAX_WIDTH) && (height >= kdim);
    delay    = rad2 ? ({1'b0, width, 1'b0} + 13'd4) : ({2'b0, width} + 13'd2);
    take     = s_tvalid && adv && geom_ok && (s_tuser == done);
    emit     = take && (s_tuser || (lead == delay));
    last     = (orow == height - 12'd1) && (ocol == width - 11'd1);
    col_wrap = (col + 11'd1 == width);
    rlo      = rad2 ? 11'd2 : 11'd1;
    rlim     = width - 11'd1 - rlo;
    rsel     = ocol + {rlo[9:0], 1'b0} + 11'd1 - width;
    // border columns pick the nearest blurred column from the history
    if (ocol < rlo) begin
      sel = ocol[2:0];
    end else if (ocol > rlim) begin
      sel = rsel[2:0];
    end else begin
      sel = rlo[2:0];
    end
    raw_sel = (orow < {1'b0, rlo}) || (orow >= height - {1'b0, rlo});
    req.v            = take;
    req.wr           = take && !s_tuser;
    req.slot         = slot;
    req.addr         = col;
    req.pixel        = s_tuser ? 8'd0 : s_tdata;
    req.meta.emit    = emit;
    req.meta.fend    = last;
    req.meta.raw_sel = raw_sel;
    req.meta.sel     = sel;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      width  <= 11'd1024;
      height <= 12'd768;
      mode   <= MODE_G273;
      col    <= '0;
      row    <= '0;
      slot   <= '0;
      done   <= 1'b0;
      lead   <= '0;
      ocol   <= '0;
      orow   <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_WIDTH:  width  <= cfg_data[10:0];
        REG_HEIGHT: height <= cfg_data;
        REG_MODE:   mode   <= cfg_data[1:0];
        default: ;
      endcase
      if (cfg_index != REG_SPARE) begin
        col  <= '0;
        row  <= '0;
        slot <= '0;
        done <= 1'b0;
        lead <= '0;
        ocol <= '0;
        orow <= '0;
      end
    end else if (take) begin
      // drain items advance the virtual position too, so the window keeps moving
      if (col_wrap) begin
        col  <= '0;
        slot <= slot + 2'd1;
        if (!s_tuser) begin
          row <= row + 12'd1;
          if (row + 12'd1 == height) begin
            done <= 1'b1;
          end
        end
      end else begin
        col <= col + 11'd1;
      end
      if (!s_tuser && lead != delay) begin
        lead <= lead + 13'd1;
      end
      if (emit) begin
        if (ocol == width - 11'd1) begin
          ocol <= '0;
          orow <= orow + 12'd1;
        end else begin
          ocol <= ocol + 11'd1;
        end
      end
      if (emit && last) begin
        col  <= '0;
        row  <= '0;
        slot <= '0;
        done <= 1'b0;
        lead <= '0;
        ocol <= '0;
        orow <= '0;
      end
    end
  end

endmodule
`default_nettype wire

/* src/gbl_linebuf.sv */
// Four row banks and the column fetch stage.
`default_nettype none
module gbl_linebuf #(
  parameter int MAX_WIDTH = 1024
) (
  input  wire                clk,
  input  wire                rst,
  input  wire                adv,
  input  gbl_pkg::req_t      req,
  output logic               v1,
  output gbl_pkg::meta_t     meta1,
  output gbl_pkg::col_t      column
);
  import gbl_pkg::*;

  localparam int DEPTH = (MAX_WIDTH < 2048) ? MAX_WIDTH : 2048;
  localparam int AW    = $clog2(DEPTH);

  logic [AW-1:0] addr;
  logic [7:0]    rd [4];
  logic [1:0]    slot1;
  logic [7:0]    pix1;

  assign addr = req.addr[AW-1:0];

  for (genvar b = 0; b < 4; b++) begin : g_bank
    logic [7:0] mem [DEPTH];
    logic [7:0] rd_q;
    // read-first: the oldest row in this bank is read before it is replaced
    always_ff @(posedge clk) begin
      if (adv && req.v) begin
        if (req.wr && req.slot == 2'(b)) begin
          mem[addr] <= req.pixel;
        end
        rd_q <= mem[addr];
      end
    end
    assign rd[b] = rd_q;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (adv) begin
      v1 <= req.v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      slot1 <= req.slot;
      pix1  <= req.pixel;
      meta1 <= req.meta;
    end
  end

  always_comb begin
    column[0] = pix1;
    for (int k = 1; k < 5; k++) begin
      column[k] = rd[slot1 - 2'(k)];
    end
  end

endmodule
`default_nettype wire

/* src/gbl_filter.sv */
// Window, symmetric class sums, kernel weighting and reciprocal divide.
`default_nettype none
module gbl_filter (
  input  wire                clk,
  input  wire                rst,
  input  wire                adv,
  input  wire  [1:0]         mode,
  input  wire                v1,
  input  gbl_pkg::meta_t     meta1,
  input  gbl_pkg::col_t      column,
  output logic               v5,
  output gbl_pkg::meta_t     meta5,
  output logic [7:0]         raw5,
  output logic [7:0]         q5
);
  import gbl_pkg::*;

  // win[i][j]: row i (4 newest), column j (4 newest)
  logic [4:0][4:0][7:0] win;
  logic        v2, v3, v4;
  meta_t       meta2, meta3, meta4;
  logic [7:0]  raw2, raw3, raw4;
  logic [7:0]  s00, t00;
  logic [9:0]  s01, s02, s11, s22, t01, t11;
  logic [10:0] s12;
  logic [16:0] wsum;
  logic [21:0] mul;
  logic [38:0] prod;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else if (adv) begin
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (v1) begin
        for (int i = 0; i < 5; i++) begin
          for (int j = 0; j < 4; j++) begin
            win[i][j] <= win[i][j+1];
          end
          win[i][4] <= column[4-i];
        end
      end
      meta2 <= meta1;
      raw2  <= (mode != MODE_3X3) ? column[2] : column[1];

      s00 <= win[2][2];
      s01 <= 10'(win[1][2]) + 10'(win[3][2]) + 10'(win[2][1]) + 10'(win[2][3]);
      s02 <= 10'(win[0][2]) + 10'(win[4][2]) + 10'(win[2][0]) + 10'(win[2][4]);
      s11 <= 10'(win[1][1]) + 10'(win[1][3]) + 10'(win[3][1]) + 10'(win[3][3]);
      s12 <= 11'(win[0][1]) + 11'(win[0][3]) + 11'(win[4][1]) + 11'(win[4][3])
           + 11'(win[1][0]) + 11'(win[3][0]) + 11'(win[1][4]) + 11'(win[3][4]);
      s22 <= 10'(win[0][0]) + 10'(win[0][4]) + 10'(win[4][0]) + 10'(win[4][4]);
      t00 <= win[3][3];
      t01 <= 10'(win[2][3]) + 10'(win[4][3]) + 10'(win[3][2]) + 10'(win[3][4]);
      t11 <= 10'(win[2][2]) + 10'(win[2][4]) + 10'(win[4][2]) + 10'(win[4][4]);
      meta3 <= meta2;
      raw3  <= raw2;

      case (mode)
        MODE_3X3:  wsum <= 17'(t00) * 17'd4 + 17'(t01) * 17'd2 + 17'(t11);
        MODE_G273: wsum <= 17'(s00) * 17'd41 + 17'(s01) * 17'd26 + 17'(s02) * 17'd7
                         + 17'(s11) * 17'd16 + 17'(s12) * 17'd4 + 17'(s22);
        default:   wsum <= 17'(s00) * 17'd64 + 17'(s01) * 17'd32 + 17'(s02) * 17'd8
                         + 17'(s11) * 17'd16 + 17'(s12) * 17'd4 + 17'(s22);
      endcase
      meta4 <= meta3;
      raw4  <= raw3;

      prod  <= 39'(wsum) * 39'(mul);
      meta5 <= meta4;
      raw5  <= raw4;
    end
  end

  always_comb begin
    case (mode)
      MODE_3X3:  mul = MUL_3X3;
      MODE_G273: mul = MUL_273;
      default:   mul = MUL_324;
    endcase
  end

  assign q5 = prod[DIV_SHIFT+7:DIV_SHIFT];

endmodule
`default_nettype wire
